@@ hdl/mvna_pkg.sv @@
// shared types, constants and codes of the vertex normal accumulator
package mvna_pkg;

	localparam int VERTEX_COUNT_DEF = 1024;
	localparam int COORD_BITS_DEF   = 16;

	// fixed field and store widths
	localparam int IDX_W   = 10;
	localparam int COORD_W = 16;
	localparam int ACC_W   = 48;
	localparam int NORM_W  = 16;
	localparam int FRAC_W  = NORM_W - 1;

	// divider gives floor(2^30 a^2 / s), at most 2^30; root of that is at most 2^15
	localparam int DIV_STEPS  = 2 * FRAC_W + 1;
	localparam int SQRT_STEPS = FRAC_W + 1;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_TRI   = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	// spare code, ignored with no result
	localparam logic [1:0] OP_SPARE = 2'd3;

	typedef struct packed {
		logic [1:0]                op;
		logic [IDX_W-1:0]          vert_idx;
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
		logic [IDX_W-1:0]          corner_a;
		logic [IDX_W-1:0]          corner_b;
		logic [IDX_W-1:0]          corner_c;
	} in_word_t;

	typedef struct packed {
		logic signed [NORM_W-1:0] normal_x;
		logic signed [NORM_W-1:0] normal_y;
		logic signed [NORM_W-1:0] normal_z;
		logic                     zero_length;
	} out_word_t;

	typedef struct packed {
		logic                    start;
		logic signed [ACC_W-1:0] acc_x;
		logic signed [ACC_W-1:0] acc_y;
		logic signed [ACC_W-1:0] acc_z;
	} norm_req_t;

	typedef struct packed {
		logic      done;
		out_word_t word;
	} norm_rsp_t;

endpackage

@@ hdl/mvna_in_if.sv @@
// input channel of the vertex normal accumulator
interface mvna_in_if;
	logic                 valid;
	logic                 ready;
	mvna_pkg::in_word_t   data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ hdl/mvna_out_if.sv @@
// result channel of the vertex normal accumulator
interface mvna_out_if;
	logic                 valid;
	logic                 ready;
	mvna_pkg::out_word_t  data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ hdl/mvna_ram.sv @@
// generic single-write, single-read ram with registered read data
module mvna_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ hdl/mvna_norm.sv @@
// bit-serial normaliser: squares, long division and square root per component
module mvna_norm (
	input  logic                clk,
	input  logic                arst_n,
	input  mvna_pkg::norm_req_t req,
	output mvna_pkg::norm_rsp_t rsp
);
	localparam int AW  = mvna_pkg::ACC_W;
	localparam int QW  = 2 * AW;
	localparam int SSW = QW + 2;
	localparam int RW  = SSW + 1;
	localparam int DS  = mvna_pkg::DIV_STEPS;
	localparam int YW  = DS + 1;
	localparam int NW  = mvna_pkg::NORM_W;

	localparam logic [2:0] N_IDLE = 3'd0;
	localparam logic [2:0] N_SQ   = 3'd1;
	localparam logic [2:0] N_SUM  = 3'd2;
	localparam logic [2:0] N_DIV  = 3'd3;
	localparam logic [2:0] N_SQRT = 3'd4;

	logic [2:0]  state_q;
	logic [5:0]  cnt_q;
	logic [1:0]  comp_q;
	logic        done_q;

	logic [QW-1:0]  mc_q [3];
	logic [AW-1:0]  mp_q [3];
	logic [QW-1:0]  sq_q [3];
	logic           neg_q [3];
	logic [SSW-1:0] s_q;
	logic [RW-1:0]  rem_q;
	logic [DS-1:0]  quo_q;
	logic [YW-1:0]  y_q;
	logic [YW-1:0]  root_q;
	logic [YW-1:0]  bit_q;
	logic signed [NW-1:0] nrm_q [3];
	logic           zl_q;

	logic [AW-1:0]  mag [3];
	logic           all_zero;
	logic           ge;
	logic [RW-1:0]  rem_nx;
	logic [YW-1:0]  t_sum;
	logic           take;
	logic [YW-1:0]  y_nx;
	logic [YW-1:0]  root_nx;
	logic [16:0]    q17;
	logic           neg_sel;
	logic signed [NW-1:0] conv;
	logic           div_last;
	logic           sqrt_last;
	logic           sq_last;

	// magnitudes of the accumulators
	always_comb begin
		mag[0] = req.acc_x[AW-1] ? AW'(-req.acc_x) : AW'(req.acc_x);
		mag[1] = req.acc_y[AW-1] ? AW'(-req.acc_y) : AW'(req.acc_y);
		mag[2] = req.acc_z[AW-1] ? AW'(-req.acc_z) : AW'(req.acc_z);
		all_zero = (req.acc_x == '0) && (req.acc_y == '0) && (req.acc_z == '0);
	end

	// divider and square root steps
	always_comb begin
		ge      = rem_q >= RW'(s_q);
		rem_nx  = ge ? rem_q - RW'(s_q) : rem_q;
		t_sum   = root_q + bit_q;
		take    = y_q >= t_sum;
		y_nx    = take ? y_q - t_sum : y_q;
		root_nx = take ? (root_q >> 1) + bit_q : (root_q >> 1);
		q17     = root_nx[16:0];
		unique case (comp_q)
			2'd0:    neg_sel = neg_q[0];
			2'd1:    neg_sel = neg_q[1];
			default: neg_sel = neg_q[2];
		endcase
		if (neg_sel) begin
			conv = NW'(-q17);
		end else if (q17 > 17'd32767) begin
			conv = NW'(17'd32767);
		end else begin
			conv = NW'(q17);
		end
		sq_last   = cnt_q == 6'(AW - 1);
		div_last  = cnt_q == 6'(DS - 1);
		sqrt_last = cnt_q == 6'(mvna_pkg::SQRT_STEPS - 1);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			cnt_q   <= '0;
			comp_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			// done pulse: zero vector at once, otherwise after the last root
			done_q <= (state_q == N_IDLE && req.start && all_zero) ||
			          (state_q == N_SQRT && sqrt_last && comp_q == 2'd2);
			unique case (state_q)
				N_IDLE: begin
					cnt_q <= '0;
					if (req.start && !all_zero) begin
						state_q <= N_SQ;
					end
				end
				N_SQ: begin
					cnt_q <= cnt_q + 6'd1;
					if (sq_last) begin
						state_q <= N_SUM;
					end
				end
				N_SUM: begin
					cnt_q   <= '0;
					comp_q  <= '0;
					state_q <= N_DIV;
				end
				N_DIV: begin
					cnt_q <= div_last ? '0 : cnt_q + 6'd1;
					if (div_last) begin
						state_q <= N_SQRT;
					end
				end
				N_SQRT: begin
					cnt_q <= sqrt_last ? '0 : cnt_q + 6'd1;
					if (sqrt_last) begin
						if (comp_q == 2'd2) begin
							state_q <= N_IDLE;
						end else begin
							comp_q  <= comp_q + 2'd1;
							state_q <= N_DIV;
						end
					end
				end
				default: state_q <= N_IDLE;
			endcase
		end
	end

	// datapath shift registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			N_IDLE: begin
				if (req.start) begin
					for (int k = 0; k < 3; k++) begin
						mc_q[k]  <= QW'(mag[k]);
						mp_q[k]  <= mag[k];
						sq_q[k]  <= '0;
						nrm_q[k] <= '0;
					end
					neg_q[0] <= req.acc_x[AW-1];
					neg_q[1] <= req.acc_y[AW-1];
					neg_q[2] <= req.acc_z[AW-1];
					zl_q     <= all_zero;
				end
			end
			N_SQ: begin
				for (int k = 0; k < 3; k++) begin
					if (mp_q[k][0]) begin
						sq_q[k] <= sq_q[k] + mc_q[k];
					end
					mc_q[k] <= mc_q[k] << 1;
					mp_q[k] <= mp_q[k] >> 1;
				end
			end
			N_SUM: begin
				s_q   <= SSW'(sq_q[0]) + SSW'(sq_q[1]) + SSW'(sq_q[2]);
				rem_q <= RW'(sq_q[0]);
			end
			N_DIV: begin
				rem_q <= {rem_nx[RW-2:0], 1'b0};
				quo_q <= {quo_q[DS-2:0], ge};
				if (div_last) begin
					y_q    <= YW'({quo_q[DS-2:0], ge});
					root_q <= '0;
					bit_q  <= YW'(1) << (DS - 1);
				end
			end
			N_SQRT: begin
				y_q    <= y_nx;
				root_q <= root_nx;
				bit_q  <= bit_q >> 2;
				if (sqrt_last) begin
					unique case (comp_q)
						2'd0: begin
							nrm_q[0] <= conv;
							rem_q    <= RW'(sq_q[1]);
						end
						2'd1: begin
							nrm_q[1] <= conv;
							rem_q    <= RW'(sq_q[2]);
						end
						default: nrm_q[2] <= conv;
					endcase
				end
			end
			default: ;
		endcase
	end

	assign rsp.done             = done_q;
	assign rsp.word.normal_x    = nrm_q[0];
	assign rsp.word.normal_y    = nrm_q[1];
	assign rsp.word.normal_z    = nrm_q[2];
	assign rsp.word.zero_length = zl_q;
endmodule

@@ hdl/mesh_vertex_normal_accumulator.sv @@
// top level: position and accumulator stores, serial cross product, normal read-out
//
// channel | dir | word                                  | accepted when
// req     | in  | op, vert_idx, pos_x/y/z, corner_a/b/c | req.valid && req.ready
// rsp     | out | normal_x/y/z, zero_length             | rsp.valid && rsp.ready
//
// one word at a time; a position write leaves the input open; a triangle closes it for its
// corner reads, edges, two serial products per lane and three accumulator read-modify-writes,
// a normal read for a 48-step squarer, then per component a 31-step divider and a 16-step
// square root, and a zero or out-of-range read only until its result is handed on.
// reset clears control only; the stores hold nothing until written.
// a result waits in the output register; a read that finishes meanwhile holds until it is free.
module mesh_vertex_normal_accumulator #(
	parameter int VERTEX_COUNT = mvna_pkg::VERTEX_COUNT_DEF,
	parameter int COORD_BITS   = mvna_pkg::COORD_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	mvna_in_if.sink      req,
	mvna_out_if.source   rsp
);
	localparam int IW  = $clog2(VERTEX_COUNT);
	localparam int CB  = COORD_BITS;
	localparam int EW  = CB + 1;
	localparam int NW  = 2 * EW + 1;
	localparam int AW  = mvna_pkg::ACC_W;
	localparam int SW  = ((NW > AW) ? NW : AW) + 1;
	localparam int CW  = $clog2(EW);
	localparam int PW  = 3 * CB;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_TRD  = 4'd1;
	localparam logic [3:0] S_TE   = 4'd2;
	localparam logic [3:0] S_TLD  = 4'd3;
	localparam logic [3:0] S_TMUL = 4'd4;
	localparam logic [3:0] S_ARD  = 4'd5;
	localparam logic [3:0] S_AWR  = 4'd6;
	localparam logic [3:0] S_NLD  = 4'd7;
	localparam logic [3:0] S_NRUN = 4'd8;
	localparam logic [3:0] S_RES  = 4'd9;

	localparam logic signed [SW-1:0] AMAX = SW'({1'b0, {(AW-1){1'b1}}});
	localparam logic signed [SW-1:0] AMIN = ~AMAX;

	logic [3:0]    state_q;
	logic [1:0]    rc_q;
	logic [1:0]    ci_q;
	logic [CW-1:0] cnt_q;
	logic          ph_q;
	logic          out_valid_q;
	mvna_pkg::out_word_t out_q;
	mvna_pkg::out_word_t res_q;

	logic [IW-1:0]          corner_q [3];
	logic signed [CB-1:0]   p_q [3][3];
	logic signed [EW-1:0]   e1_q [3];
	logic signed [EW-1:0]   e2_q [3];
	logic signed [NW-1:0]   mc_q [3];
	logic [EW-1:0]          mp_q [3];
	logic signed [NW-1:0]   nacc_q [3];

	logic           acc_in;
	logic           vi_ok;
	logic           tri_ok;
	logic           pos_we;
	logic [PW-1:0]  pos_wdata;
	logic [IW-1:0]  pos_raddr;
	logic [PW-1:0]  pos_rdata;
	logic           acc_we;
	logic [IW-1:0]  acc_waddr;
	logic [3*AW-1:0] acc_wdata;
	logic [IW-1:0]  acc_raddr;
	logic [3*AW-1:0] acc_rdata;
	logic [3*AW-1:0] sat_word;
	logic [IW-1:0]  rc_corner;
	logic [IW-1:0]  ci_corner;
	logic           mul_last;
	logic           out_free;
	mvna_pkg::norm_req_t nreq;
	mvna_pkg::norm_rsp_t nrsp;

	// handshake and index checks
	always_comb begin
		req.ready = state_q == S_IDLE;
		acc_in    = req.valid && req.ready;
		vi_ok     = 32'(req.data.vert_idx) < 32'(VERTEX_COUNT);
		tri_ok    = (32'(req.data.corner_a) < 32'(VERTEX_COUNT)) &&
		            (32'(req.data.corner_b) < 32'(VERTEX_COUNT)) &&
		            (32'(req.data.corner_c) < 32'(VERTEX_COUNT));
		mul_last  = cnt_q == CW'(EW - 1);
		out_free  = !out_valid_q || rsp.ready;
		unique case (rc_q)
			2'd0:    rc_corner = corner_q[0];
			2'd1:    rc_corner = corner_q[1];
			default: rc_corner = corner_q[2];
		endcase
		unique case (ci_q)
			2'd0:    ci_corner = corner_q[0];
			2'd1:    ci_corner = corner_q[1];
			default: ci_corner = corner_q[2];
		endcase
	end

	// store port selection
	always_comb begin
		pos_we    = acc_in && (req.data.op == mvna_pkg::OP_WRITE) && vi_ok;
		pos_wdata = {CB'($unsigned(req.data.pos_z)), CB'($unsigned(req.data.pos_y)),
		             CB'($unsigned(req.data.pos_x))};
		pos_raddr = rc_corner;
		acc_we    = pos_we || (state_q == S_AWR);
		acc_waddr = (state_q == S_AWR) ? ci_corner : IW'(req.data.vert_idx);
		acc_wdata = (state_q == S_AWR) ? sat_word : '0;
		acc_raddr = (state_q == S_IDLE) ? IW'(req.data.vert_idx) : ci_corner;
	end

	// saturating add of the cross product into one corner's accumulators
	always_comb begin
		logic signed [AW-1:0] old_v;
		logic signed [SW-1:0] s;
		for (int k = 0; k < 3; k++) begin
			old_v = acc_rdata[k*AW +: AW];
			s     = SW'(old_v) + SW'(nacc_q[k]);
			if (s > AMAX) begin
				sat_word[k*AW +: AW] = AMAX[AW-1:0];
			end else if (s < AMIN) begin
				sat_word[k*AW +: AW] = AMIN[AW-1:0];
			end else begin
				sat_word[k*AW +: AW] = s[AW-1:0];
			end
		end
	end

	mvna_ram #(.WIDTH(PW), .DEPTH(VERTEX_COUNT)) u_pos_ram (
		.clk  (clk),
		.we   (pos_we),
		.waddr(IW'(req.data.vert_idx)),
		.wdata(pos_wdata),
		.raddr(pos_raddr),
		.rdata(pos_rdata)
	);

	mvna_ram #(.WIDTH(3*AW), .DEPTH(VERTEX_COUNT)) u_acc_ram (
		.clk  (clk),
		.we   (acc_we),
		.waddr(acc_waddr),
		.wdata(acc_wdata),
		.raddr(acc_raddr),
		.rdata(acc_rdata)
	);

	// normaliser request
	always_comb begin
		nreq.start = state_q == S_NLD;
		nreq.acc_x = acc_rdata[0*AW +: AW];
		nreq.acc_y = acc_rdata[1*AW +: AW];
		nreq.acc_z = acc_rdata[2*AW +: AW];
	end

	mvna_norm u_norm (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (nreq),
		.rsp   (nrsp)
	);

	// sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rc_q        <= '0;
			ci_q        <= '0;
			cnt_q       <= '0;
			ph_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_RES && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					rc_q <= '0;
					ci_q <= '0;
					if (acc_in) begin
						if (req.data.op == mvna_pkg::OP_TRI && tri_ok) begin
							state_q <= S_TRD;
						end else if (req.data.op == mvna_pkg::OP_READ) begin
							state_q <= vi_ok ? S_NLD : S_RES;
						end
					end
				end
				S_TRD: begin
					rc_q <= rc_q + 2'd1;
					if (rc_q == 2'd3) begin
						state_q <= S_TE;
					end
				end
				S_TE:  state_q <= S_TLD;
				S_TLD: begin
					cnt_q   <= '0;
					ph_q    <= 1'b0;
					state_q <= S_TMUL;
				end
				S_TMUL: begin
					cnt_q <= mul_last ? '0 : cnt_q + CW'(1);
					if (mul_last) begin
						ph_q <= 1'b1;
						if (ph_q) begin
							state_q <= S_ARD;
						end
					end
				end
				S_ARD: state_q <= S_AWR;
				S_AWR: begin
					ci_q    <= ci_q + 2'd1;
					state_q <= (ci_q == 2'd2) ? S_IDLE : S_ARD;
				end
				S_NLD:  state_q <= S_NRUN;
				S_NRUN: begin
					if (nrsp.done) begin
						state_q <= S_RES;
					end
				end
				S_RES: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (acc_in) begin
			corner_q[0] <= IW'(req.data.corner_a);
			corner_q[1] <= IW'(req.data.corner_b);
			corner_q[2] <= IW'(req.data.corner_c);
			res_q       <= '{normal_x: '0, normal_y: '0, normal_z: '0, zero_length: 1'b1};
		end
		// capture each corner position in the cycle after its read
		if (state_q == S_TRD && rc_q != 2'd0) begin
			for (int k = 0; k < 3; k++) begin
				unique case (rc_q)
					2'd1:    p_q[0][k] <= pos_rdata[k*CB +: CB];
					2'd2:    p_q[1][k] <= pos_rdata[k*CB +: CB];
					default: p_q[2][k] <= pos_rdata[k*CB +: CB];
				endcase
			end
		end
		// edge vectors
		if (state_q == S_TE) begin
			for (int k = 0; k < 3; k++) begin
				e1_q[k] <= EW'(p_q[1][k]) - EW'(p_q[0][k]);
				e2_q[k] <= EW'(p_q[2][k]) - EW'(p_q[0][k]);
			end
		end
		// serial cross product lanes: first product added, second subtracted
		if (state_q == S_TLD) begin
			for (int k = 0; k < 3; k++) begin
				mc_q[k]   <= NW'(e1_q[(k + 1) % 3]);
				mp_q[k]   <= e2_q[(k + 2) % 3];
				nacc_q[k] <= '0;
			end
		end
		if (state_q == S_TMUL) begin
			for (int k = 0; k < 3; k++) begin
				if (mp_q[k][0]) begin
					if (ph_q ^ mul_last) begin
						nacc_q[k] <= nacc_q[k] - mc_q[k];
					end else begin
						nacc_q[k] <= nacc_q[k] + mc_q[k];
					end
				end
				if (mul_last && !ph_q) begin
					mc_q[k] <= NW'(e1_q[(k + 2) % 3]);
					mp_q[k] <= e2_q[(k + 1) % 3];
				end else begin
					mc_q[k] <= mc_q[k] << 1;
					mp_q[k] <= mp_q[k] >> 1;
				end
			end
		end
		if (state_q == S_NRUN && nrsp.done) begin
			res_q <= nrsp.word;
		end
		if (state_q == S_RES && out_free) begin
			out_q <= res_q;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;
endmodule

@@ dv/tb.sv @@
// self-checking testbench of the vertex normal accumulator
`timescale 1ns / 100ps

module tb;
	localparam int MAX_REPORTS    = 10;
	localparam int CALM_TRIANGLES = 40;
	localparam int RANDOM_ITEMS   = 330;
	localparam int VCOUNT  = mvna_pkg::VERTEX_COUNT_DEF;
	localparam int IDX_W   = mvna_pkg::IDX_W;
	localparam int COORD_W = mvna_pkg::COORD_W;
	localparam int ACC_W   = mvna_pkg::ACC_W;
	localparam int NORM_W  = mvna_pkg::NORM_W;
	localparam int WORD_W  = $bits(mvna_pkg::in_word_t);

	typedef struct {
		mvna_pkg::in_word_t w;
		bit                 drain;
		bit                 calm;
	} pending_t;

	logic clk;
	logic arst_n;

	mvna_in_if  req();
	mvna_out_if rsp();

	mesh_vertex_normal_accumulator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// predictor state
	logic signed [COORD_W-1:0] pos_mem [VCOUNT][3];
	logic signed [ACC_W-1:0]   acc_mem [VCOUNT][3];

	// stimulus bookkeeping
	pending_t             pend_q[$];
	mvna_pkg::out_word_t  normal_q[$];
	bit                   written[VCOUNT];
	int                   written_list[$];
	int                   err_cnt;
	bit                   calm;
	int                   in_gap;
	int                   out_gap;

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// clamp a sum to the accumulator range
	function automatic logic signed [ACC_W-1:0] sat_add(logic signed [ACC_W-1:0] acc,
			longint d);
		longint s;
		longint hi_lim;
		hi_lim = (longint'(1) <<< (ACC_W - 1)) - 1;
		s = longint'(acc) + d;
		if (s > hi_lim)
			s = hi_lim;
		else if (s < -hi_lim - 1)
			s = -hi_lim - 1;
		return s[ACC_W-1:0];
	endfunction

	// exact truncated unit component: largest q with q^2 * sum <= 2^30 * a^2
	function automatic logic signed [NORM_W-1:0] unit_part(longint a, logic [127:0] sum);
		logic [127:0] m;
		logic [127:0] target;
		logic [127:0] t;
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mid;
		longint q;
		m = (a < 0) ? 128'(-a) : 128'(a);
		target = (m * m) << 30;
		lo = 0;
		hi = 32768;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			t = sum * 128'(mid * mid);
			if (t <= target)
				lo = mid;
			else
				hi = mid - 1;
		end
		q = longint'(lo);
		if (a < 0)
			q = -q;
		if (q > 32767)
			q = 32767;
		return q[NORM_W-1:0];
	endfunction

	// apply one accepted word to the predictor, queue the normal it produces
	task automatic predict_word(mvna_pkg::in_word_t w);
		int c [3];
		longint e1 [3];
		longint e2 [3];
		longint n [3];
		longint a [3];
		logic [127:0] sum;
		mvna_pkg::out_word_t r;
		case (w.op)
			mvna_pkg::OP_WRITE: begin
				pos_mem[w.vert_idx][0] = w.pos_x;
				pos_mem[w.vert_idx][1] = w.pos_y;
				pos_mem[w.vert_idx][2] = w.pos_z;
				for (int k = 0; k < 3; k++)
					acc_mem[w.vert_idx][k] = '0;
			end
			mvna_pkg::OP_TRI: begin
				c[0] = int'(w.corner_a);
				c[1] = int'(w.corner_b);
				c[2] = int'(w.corner_c);
				for (int k = 0; k < 3; k++) begin
					e1[k] = longint'(pos_mem[c[1]][k]) - longint'(pos_mem[c[0]][k]);
					e2[k] = longint'(pos_mem[c[2]][k]) - longint'(pos_mem[c[0]][k]);
				end
				n[0] = e1[1] * e2[2] - e1[2] * e2[1];
				n[1] = e1[2] * e2[0] - e1[0] * e2[2];
				n[2] = e1[0] * e2[1] - e1[1] * e2[0];
				// a corner named twice takes the sum once per naming
				for (int j = 0; j < 3; j++)
					for (int k = 0; k < 3; k++)
						acc_mem[c[j]][k] = sat_add(acc_mem[c[j]][k], n[k]);
			end
			mvna_pkg::OP_READ: begin
				r = '0;
				r.zero_length = 1'b1;
				for (int k = 0; k < 3; k++)
					a[k] = longint'(acc_mem[w.vert_idx][k]);
				if (a[0] != 0 || a[1] != 0 || a[2] != 0) begin
					sum = '0;
					for (int k = 0; k < 3; k++)
						sum = sum + 128'(a[k] < 0 ? -a[k] : a[k]) *
							128'(a[k] < 0 ? -a[k] : a[k]);
					r.normal_x = unit_part(a[0], sum);
					r.normal_y = unit_part(a[1], sum);
					r.normal_z = unit_part(a[2], sum);
					r.zero_length = 1'b0;
				end
				normal_q.insert(normal_q.size(), r);
			end
			default: ;
		endcase
	endtask

	// queue helpers for the stimulus
	task automatic add_item(mvna_pkg::in_word_t w, bit drain = 0, bit quiet = 0);
		pending_t p;
		p.w = w;
		p.drain = drain;
		p.calm = quiet;
		pend_q.insert(pend_q.size(), p);
		if (w.op == mvna_pkg::OP_WRITE && !written[w.vert_idx]) begin
			written[w.vert_idx] = 1'b1;
			written_list.insert(written_list.size(), int'(w.vert_idx));
		end
	endtask

	function automatic mvna_pkg::in_word_t rand_word();
		logic [95:0] r;
		r = {$urandom, $urandom, $urandom};
		return mvna_pkg::in_word_t'(r[WORD_W-1:0]);
	endfunction

	function automatic mvna_pkg::in_word_t mk_write(int vi, int x, int y, int z);
		mvna_pkg::in_word_t w;
		w = rand_word();
		w.op = mvna_pkg::OP_WRITE;
		w.vert_idx = IDX_W'(vi);
		w.pos_x = COORD_W'(x);
		w.pos_y = COORD_W'(y);
		w.pos_z = COORD_W'(z);
		return w;
	endfunction

	function automatic mvna_pkg::in_word_t mk_tri(int a, int b, int c);
		mvna_pkg::in_word_t w;
		w = rand_word();
		w.op = mvna_pkg::OP_TRI;
		w.corner_a = IDX_W'(a);
		w.corner_b = IDX_W'(b);
		w.corner_c = IDX_W'(c);
		return w;
	endfunction

	function automatic mvna_pkg::in_word_t mk_read(int vi);
		mvna_pkg::in_word_t w;
		w = rand_word();
		w.op = mvna_pkg::OP_READ;
		w.vert_idx = IDX_W'(vi);
		return w;
	endfunction

	function automatic int pick_written();
		return written_list[$urandom_range(0, written_list.size() - 1)];
	endfunction

	function automatic int rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 1) ? 32767 : -32768;
			1: return int'($urandom_range(0, 400)) - 200;
			default: return int'($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	// stimulus
	initial begin
		mvna_pkg::in_word_t w;
		int a;
		int b;
		int c;
		// directed: extremes, zero and axis-aligned normals, repeated corners, unused op
		add_item(mk_write(0, -32768, -32768, -32768));
		add_item(mk_write(1023, 32767, 32767, 32767));
		add_item(mk_write(1, 0, 0, 0));
		add_item(mk_read(0));
		add_item(mk_tri(0, 1023, 1));
		add_item(mk_read(1023));
		add_item(mk_write(2, 0, 0, 0));
		add_item(mk_write(3, 100, 0, 0));
		add_item(mk_write(4, 0, 100, 0));
		add_item(mk_tri(2, 3, 4));
		add_item(mk_read(2));
		add_item(mk_tri(2, 4, 3));
		add_item(mk_tri(2, 4, 3));
		add_item(mk_read(3));
		add_item(mk_tri(2, 2, 3));
		add_item(mk_tri(3, 3, 3));
		add_item(mk_read(4));
		add_item(mk_write(5, -32768, 32767, 12345));
		add_item(mk_tri(5, 0, 1023));
		add_item(mk_tri(1023, 5, 2));
		add_item(mk_read(5));
		w = rand_word();
		w.op = mvna_pkg::OP_SPARE;
		add_item(w);
		add_item(mk_write(2, 7, -9, 11));
		add_item(mk_read(2));
		// random part: mostly valid meshes, some overwrites and unused ops
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5: begin
					if ($urandom_range(0, 2) == 0)
						a = $urandom_range(0, VCOUNT - 1);
					else
						a = $urandom_range(0, 31);
					add_item(mk_write(a, rand_coord(), rand_coord(), rand_coord()));
				end
				6, 7, 8, 9, 10, 11, 12, 13, 14: begin
					a = pick_written();
					b = pick_written();
					c = $urandom_range(0, 5) == 0 ? a : pick_written();
					add_item(mk_tri(a, b, c));
				end
				19: begin
					w = rand_word();
					w.op = mvna_pkg::OP_SPARE;
					add_item(w);
				end
				default:
					add_item(mk_read(pick_written()), i == 200);
			endcase
		end
		// closing run: maximal-area triangles with no idling
		add_item(mk_write(1000, -32768, -32768, 0), 1'b1, 1'b1);
		add_item(mk_write(1001, 32767, -32768, 0), 1'b0, 1'b1);
		add_item(mk_write(1002, -32768, 32767, 0), 1'b0, 1'b1);
		for (int i = 0; i < CALM_TRIANGLES; i++) begin
			add_item(mk_tri(1000, 1001, 1002), 1'b0, 1'b1);
			if (i == CALM_TRIANGLES / 2)
				add_item(mk_read(1001), 1'b0, 1'b1);
		end
		add_item(mk_read(1000), 1'b0, 1'b1);
		add_item(mk_read(1001), 1'b0, 1'b1);
		add_item(mk_read(1002), 1'b0, 1'b1);
	end

	// reset and end of run
	initial begin
		err_cnt = 0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (pend_q.size() != 0 || req.valid)
			@(posedge clk);
		while (normal_q.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
		if (err_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// watchdog
	initial begin
		#50ms;
		$display("RESULT: ERROR");
		$finish;
	end

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.data  <= '0;
			in_gap    <= 0;
			calm      <= 1'b0;
		end else if (!req.valid || req.ready) begin
			if (in_gap != 0) begin
				req.valid <= 1'b0;
				in_gap <= in_gap - 1;
			end else if (pend_q.size() == 0) begin
				req.valid <= 1'b0;
			end else if (pend_q[0].drain && (req.valid || normal_q.size() != 0)) begin
				// hold off until every pending normal has come back
				req.valid <= 1'b0;
			end else begin
				req.valid <= 1'b1;
				req.data  <= pend_q[0].w;
				if (pend_q[0].calm)
					calm <= 1'b1;
				if (!pend_q[0].calm && $urandom_range(0, 3) == 0)
					in_gap <= $urandom_range(1, 4);
				void'(pend_q.pop_front());
			end
		end
	end

	// result ready with random stalls, held high once the calm run has started
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			out_gap   <= 0;
		end else if (calm) begin
			rsp.ready <= 1'b1;
		end else if (out_gap != 0) begin
			rsp.ready <= 1'b0;
			out_gap <= out_gap - 1;
		end else if ($urandom_range(0, 4) == 0) begin
			rsp.ready <= 1'b0;
			out_gap <= $urandom_range(0, 3);
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	// input monitor feeds the predictor
	always @(posedge clk) begin
		if (arst_n && req.valid && req.ready)
			predict_word(req.data);
	end

	// result monitor compares against the oldest expected normal
	always @(posedge clk) begin
		mvna_pkg::out_word_t exp_w;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (normal_q.size() == 0) begin
				err_cnt++;
				if (err_cnt <= MAX_REPORTS)
					$display("unexpected word: %p", rsp.data);
			end else begin
				exp_w = normal_q.pop_front();
				if (rsp.data.normal_x !== exp_w.normal_x ||
						rsp.data.normal_y !== exp_w.normal_y ||
						rsp.data.normal_z !== exp_w.normal_z ||
						rsp.data.zero_length !== exp_w.zero_length) begin
					err_cnt++;
					if (err_cnt <= MAX_REPORTS)
						$display("mismatch: expected %0d %0d %0d z%0b, got %0d %0d %0d z%0b",
							exp_w.normal_x, exp_w.normal_y, exp_w.normal_z,
							exp_w.zero_length, rsp.data.normal_x, rsp.data.normal_y,
							rsp.data.normal_z, rsp.data.zero_length);
				end
			end
		end
	end

endmodule

@@ mesh_vertex_normal_accumulator.f @@
hdl/mvna_pkg.sv
hdl/mvna_in_if.sv
hdl/mvna_out_if.sv
hdl/mvna_ram.sv
hdl/mvna_norm.sv
hdl/mesh_vertex_normal_accumulator.sv
dv/tb.sv
